@@ rtl/sram_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sram_pkg;

   localparam int MaxSensorsDefault   = 16;
   localparam int WindowLengthDefault = 8;

   localparam logic [15:0] MinTempReset = 16'sd3840;
   localparam logic [15:0] MaxTempReset = 16'sd6400;

   localparam logic CsrMinTemp = 1'b0;
   localparam logic CsrMaxTemp = 1'b1;

   typedef enum logic {
      OP_REGISTER = 1'b0,
      OP_SAMPLE   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_PROCESSED = 2'd0,
      ST_UNKNOWN   = 2'd1,
      ST_REGISTERED = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      op_type             operation;
      logic        [15:0] device_id;
      logic        [15:0] room_id;
      logic signed [15:0] sample_value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic        [15:0] room;
      logic signed [15:0] average;
      logic               too_cold;
      logic               too_hot;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_SEARCH,
      S_MATCH,
      S_META,
      S_SUM,
      S_SUMLAST,
      S_DIV,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

@@ rtl/sram_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module sram_divider #(
   parameter int SumWidth = 32,
   parameter int DivWidth = 6
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire  signed [SumWidth-1:0]  dividend,
   input  wire         [DivWidth-1:0]  divisor,
   output logic                        done,
   output logic signed [SumWidth-1:0]  quotient
);
   localparam int CntWidth = $clog2(SumWidth + 1);

   logic [SumWidth-1:0] rem_ff, rem_in;
   logic [SumWidth-1:0] quo_ff, quo_in;
   logic [DivWidth-1:0] dvs_ff, dvs_in;
   logic                neg_ff, neg_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [SumWidth:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         neg_in = dividend[SumWidth-1];
         quo_in = dividend[SumWidth-1] ? (~dividend + 1'b1) : dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CntWidth'(SumWidth);
         run_in = 1'b1;
      end else if (run_ff) begin
         trial = {rem_ff, quo_ff[SumWidth-1]} - {{(SumWidth+1-DivWidth){1'b0}}, dvs_ff};
         if (!trial[SumWidth]) begin
            rem_in = trial[SumWidth-1:0];
            quo_in = {quo_ff[SumWidth-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[SumWidth-2:0], quo_ff[SumWidth-1]};
            quo_in = {quo_ff[SumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
endmodule
`default_nettype wire

@@ rtl/sensor_running_average_monitor.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Ports                       | Transfer rule
// request  | start, busy, req_data       | accepted at an edge with start high and busy low
// response | rsp_valid, rsp_data         | one-cycle strobe, cannot be stalled
// config   | csr_we, csr_index, csr_data | written at an edge with csr_we high, no wait
//
// One item is in flight at a time. Busy falls in the cycle that shows the result,
// and a new transfer may be accepted at the end of that cycle.
// A register operation passes through S_META and S_DONE before its result shows;
// a full table skips S_META and goes straight to S_DONE.
// A sample walks the id memory one entry per cycle, writes the sample in S_MATCH,
// sums the window in S_SUM and S_SUMLAST and then waits in S_DIV for the 32-step
// divider before S_DONE shows its result. An unknown id goes from the last search
// step to S_DONE; with no entries registered it goes there straight from S_IDLE.
// After reset a clearing pass zeroes the window memory, MAX_SENSORS times the
// window length rounded up to a power of two slots; busy is high during it.
// The receiver cannot stall results.
module sensor_running_average_monitor #(
   parameter int MAX_SENSORS   = sram_pkg::MaxSensorsDefault,
   parameter int WINDOW_LENGTH = sram_pkg::WindowLengthDefault
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  wire sram_pkg::req_type  req_data,
   output logic                    rsp_valid,
   output sram_pkg::rsp_type       rsp_data,
   input  wire                     csr_we,
   input  wire                     csr_index,
   input  wire  [15:0]             csr_data
);
   import sram_pkg::*;

   localparam int EW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
   localparam int PW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int CW = $clog2(MAX_SENSORS + 1);
   localparam int DW = $clog2(WINDOW_LENGTH + 1);
   localparam int AW = EW + PW;
   localparam int IW = 33 + PW;
   localparam int Depth = MAX_SENSORS * (2 ** PW);

   // The entry memory holds id, room, the window-full flag and the write position
   // of each sensor; the window memory holds the samples. Both have registered reads.
   logic [IW-1:0]      id_mem  [MAX_SENSORS];
   logic signed [15:0] win_mem [Depth];

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [EW-1:0] idx_ff, idx_in;
   logic [PW-1:0] slot_ff, slot_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic signed [15:0] min_ff, max_ff;
   logic signed [31:0] sum_ff, sum_in;
   logic [15:0] room_ff, room_in;
   logic [PW-1:0] wpos_ff, wpos_in;
   logic        full_ff, full_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        busy_div_ff;

   logic [EW-1:0] id_raddr, id_waddr;
   logic [IW-1:0] id_rdata, id_wdata;
   logic          id_we;
   logic [AW-1:0] win_raddr, win_waddr;
   logic signed [15:0] win_rdata, win_wdata;
   logic          win_we;
   logic          div_start, div_done;
   logic signed [31:0] quotient;
   logic [DW-1:0] divisor;
   logic signed [15:0] avg;

   always_ff @(posedge clock) begin
      if (id_we) id_mem[id_waddr] <= id_wdata;
      id_rdata <= id_mem[id_raddr];
      if (win_we) win_mem[win_waddr] <= win_wdata;
      win_rdata <= win_mem[win_raddr];
   end

   sram_divider #(.SumWidth(32), .DivWidth(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(sum_ff), .divisor(divisor),
      .done(div_done), .quotient(quotient)
   );

   assign divisor = full_ff ? DW'(WINDOW_LENGTH) : DW'({1'b0, wpos_ff} + 1'b1);
   assign avg = quotient[15:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      clr_in       = clr_ff;
      sum_in       = sum_ff;
      room_in      = room_ff;
      wpos_in      = wpos_ff;
      full_in      = full_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      id_raddr     = idx_ff;
      id_we        = 1'b0;
      id_waddr     = idx_ff;
      id_wdata     = '0;
      win_we       = 1'b0;
      win_waddr    = clr_ff;
      win_wdata    = '0;
      win_raddr    = {idx_ff, slot_ff};
      div_start    = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            // Zero the window memory one slot per cycle.
            win_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(Depth - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            idx_in = '0;
            id_raddr = '0;
            if (start) begin
               if (req_data.operation == OP_REGISTER) begin
                  rsp_in = '{status: (count_ff == CW'(MAX_SENSORS)) ? ST_FULL : ST_REGISTERED,
                             room: '0, average: '0, too_cold: 1'b0, too_hot: 1'b0};
                  state_in = (count_ff == CW'(MAX_SENSORS)) ? S_DONE : S_META;
               end else if (count_ff == '0) begin
                  rsp_in = '{status: ST_UNKNOWN, room: '0, average: '0,
                             too_cold: 1'b0, too_hot: 1'b0};
                  state_in = S_DONE;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_META: begin
            // Register operation: append the pair with an empty window.
            id_we    = 1'b1;
            id_waddr = count_ff[EW-1:0];
            id_wdata = {req_ff.device_id, req_ff.room_id, 1'b0, {PW{1'b0}}};
            count_in = count_ff + 1'b1;
            state_in = S_DONE;
         end
         S_SEARCH: begin
            // id_rdata holds entry idx_ff.
            if (id_rdata[IW-1 -: 16] == req_ff.device_id) begin
               room_in  = id_rdata[PW+16 -: 16];
               state_in = S_MATCH;
            end else if (CW'(idx_ff) + CW'(1) == count_ff) begin
               rsp_in = '{status: ST_UNKNOWN, room: '0, average: '0,
                          too_cold: 1'b0, too_hot: 1'b0};
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               id_raddr = idx_ff + 1'b1;
            end
         end
         S_MATCH: begin
            // id_rdata still holds entry idx_ff: write the sample, advance the position.
            wpos_in = id_rdata[PW-1:0];
            full_in = id_rdata[PW];
            win_we    = 1'b1;
            win_waddr = {idx_ff, id_rdata[PW-1:0]};
            win_wdata = req_ff.sample_value;
            id_we     = 1'b1;
            id_waddr  = idx_ff;
            if (id_rdata[PW-1:0] == PW'(WINDOW_LENGTH - 1))
               id_wdata = {id_rdata[IW-1:PW+1], 1'b1, {PW{1'b0}}};
            else
               id_wdata = {id_rdata[IW-1:PW], id_rdata[PW-1:0] + 1'b1};
            slot_in = '0;
            sum_in  = '0;
            state_in = S_SUM;
         end
         S_SUM: begin
            // Issue read of slot_ff; write above lands before this read.
            slot_in = slot_ff + 1'b1;
            if (slot_ff == PW'(WINDOW_LENGTH - 1)) state_in = S_SUMLAST;
            if (slot_ff != '0) sum_in = sum_ff + 32'(win_rdata);
         end
         S_SUMLAST: begin
            sum_in   = sum_ff + 32'(win_rdata);
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!div_done && !busy_div_ff) div_start = 1'b1;
            if (div_done) begin
               rsp_in = '{status: ST_PROCESSED, room: room_ff, average: avg,
                          too_cold: (avg < min_ff), too_hot: (avg > max_ff)};
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) busy_div_ff <= 1'b0;
      else if (div_start) busy_div_ff <= 1'b1;
      else if (div_done) busy_div_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         count_ff     <= '0;
         clr_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         min_ff       <= MinTempReset;
         max_ff       <= MaxTempReset;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CsrMinTemp) min_ff <= csr_data;
         if (csr_we && csr_index == CsrMaxTemp) max_ff <= csr_data;
      end
      if (state_ff == S_IDLE && start) req_ff <= req_data;
      slot_ff <= slot_in;
      sum_ff  <= sum_in;
      room_ff <= room_in;
      wpos_ff <= wpos_in;
      full_ff <= full_in;
      rsp_ff  <= rsp_in;
   end

   // Window slot read must trail the sample write; S_SUM uses registered data.
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe held");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SENSORS)) else $error("entry count overflow");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_IDLE) else $error("response outside idle");
endmodule
`default_nettype wire
